/* sv/tga_pixel_stream_decoder_unit_macros.svh */
// assertion macros shared by the checker of the pixel stream decoder
// needs signals named clk and rst in the scope where a macro is used
`ifndef TGA_PIXEL_STREAM_DECODER_UNIT_MACROS_SVH
`define TGA_PIXEL_STREAM_DECODER_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define TPSD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpsd assertion failed");

// consequent must hold in the next cycle
`define TPSD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpsd assertion failed");

`endif

/* sv/tpsd_pkg.sv */
// shared types, register codes and constants of the pixel stream decoder
// no dependencies
`timescale 1ns / 1ps

package tpsd_pkg;

  localparam int CFG_W   = 13;
  localparam int BPP_W   = 3;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 8;
  localparam int COORD_W = 12;
  localparam int LEN_W   = 8;
  localparam int COLOR_W = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_BYTES_PER_PIXEL = 3'd2,
    REG_RLE_MODE        = 3'd3,
    REG_FIRST_ROW_TOP   = 3'd4,
    REG_RIGHT_TO_LEFT   = 3'd5
  } cfg_reg_t;

  localparam logic [BPP_W-1:0] BPP_BGRA = 3'd4;
  localparam int TAG_RUN_BIT = 7;
  localparam logic [DATA_W-1:0] TAG_COUNT_MASK = 8'h7F;

  localparam logic [COLOR_W-1:0] KEY_G_MAX = 8'd50;
  localparam logic [COLOR_W-1:0] KEY_R_MIN = 8'd205;
  localparam logic [COLOR_W-1:0] KEY_D_MAX = 8'd20;
  localparam logic [9:0] KEY_SUM_MAX = 10'd60;
  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_NONE = 8'h00;

  typedef struct packed {
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] first_column;
    logic [LEN_W-1:0]   span_length;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               keyed;
    logic               clipped;
    logic               image_done;
  } span_t;

  // chroma key: reddish-magenta with low green
  function automatic logic is_key(input logic [COLOR_W-1:0] r,
                                  input logic [COLOR_W-1:0] g,
                                  input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    logic [9:0] sum;
    d   = (r > b) ? (r - b) : (b - r);
    sum = {1'b0, d, 1'b0} + {2'b00, g};
    return (g <= KEY_G_MAX) && (r >= KEY_R_MIN) && (d <= KEY_D_MAX) &&
           (sum <= KEY_SUM_MAX);
  endfunction

endpackage

/* sv/tpsd_if.sv */
// valid/ready channel interfaces: configuration writes, file bytes, spans
// depends on tpsd_pkg
`timescale 1ns / 1ps

interface tpsd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tpsd_pkg::IDX_W-1:0] index;
  logic [tpsd_pkg::CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface tpsd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [tpsd_pkg::DATA_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tpsd_span_if;
  logic                         valid;
  logic                         ready;
  logic [tpsd_pkg::COORD_W-1:0] row_index;
  logic [tpsd_pkg::COORD_W-1:0] first_column;
  logic [tpsd_pkg::LEN_W-1:0]   span_length;
  logic [tpsd_pkg::COLOR_W-1:0] red;
  logic [tpsd_pkg::COLOR_W-1:0] green;
  logic [tpsd_pkg::COLOR_W-1:0] blue;
  logic                         keyed;
  logic                         clipped;
  logic                         image_done;
  modport source (output valid, output row_index, output first_column,
                  output span_length, output red, output green, output blue,
                  output keyed, output clipped, output image_done, input ready);
  modport sink (input valid, input row_index, input first_column,
                input span_length, input red, input green, input blue,
                input keyed, input clipped, input image_done, output ready);
endinterface

/* sv/tga_pixel_stream_decoder_unit.sv */
// truecolor pixel stream decoder: file bytes in, pixel spans out (needs tpsd_pkg, tpsd_if)
// a span is registered onto span_out from the byte that completes its pixel, via the skid word on a stall
// throughput: one byte per cycle while pixel_in.ready is high;
// a two-word output stage (result register plus skid) drops pixel_in.ready only when both are full
// reset (rst, synchronous): configuration to 1x1 raw BGR bottom-up, decoder state cleared
`timescale 1ns / 1ps

module tga_pixel_stream_decoder_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input logic          clk,
  input logic          rst,
  tpsd_cfg_if.sink     cfg,
  tpsd_byte_if.sink    pixel_in,
  tpsd_span_if.source  span_out
);
  import tpsd_pkg::*;

  // counter widths follow the size limits, capped by the 13-bit size registers
  localparam int COL_W  = ($clog2(MAX_WIDTH + 1) < CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int ROW_W  = ($clog2(MAX_HEIGHT + 1) < CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int SPAN_W = (COL_W > LEN_W) ? COL_W : LEN_W;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [BPP_W-1:0] bytes_per_pixel;
  logic             rle_mode;
  logic             first_row_top;
  logic             right_to_left;

  // decoder state
  logic             expect_tag, expect_tag_next;
  logic             packet_is_run, packet_is_run_next;
  logic [7:0]       packet_left, packet_left_next;
  logic [1:0]       byte_in_pixel, byte_in_pixel_next;
  logic [23:0]      color_hold, color_hold_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [COL_W-1:0] column_count, column_count_next;
  logic             finished, finished_next;
  logic             drop_rest, drop_rest_next;

  // output stage
  logic  out_valid;
  span_t out_span;
  logic  skid_valid;
  span_t skid_span;

  // working signals
  logic              accept;
  logic              tag_step;
  logic [1:0]        last_byte;
  logic              pixel_done;
  logic [23:0]       color_new;
  logic [7:0]        packet_dec;
  logic [7:0]        want;
  logic              more_after;
  logic              do_emit;
  logic [COL_W-1:0]  width_lim;
  logic [ROW_W-1:0]  height_lim;
  logic [COL_W-1:0]  col_sat;
  logic [ROW_W-1:0]  row_sat;
  logic [COL_W-1:0]  room;
  logic [SPAN_W-1:0] want_x;
  logic [SPAN_W-1:0] room_x;
  logic [SPAN_W-1:0] len_x;
  logic              overrun;
  logic              clip;
  logic [COL_W-1:0]  col_sum;
  logic [ROW_W-1:0]  row_inc;
  logic              row_end;
  logic              last_row;
  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;
  logic              key;
  logic              result_valid;
  span_t             result_span;

  // ---------------- configuration port ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= CFG_W'(1);
      image_height    <= CFG_W'(1);
      bytes_per_pixel <= 3'd3;
      rle_mode        <= 1'b0;
      first_row_top   <= 1'b0;
      right_to_left   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:     image_width     <= cfg.data;
        REG_IMAGE_HEIGHT:    image_height    <= cfg.data;
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data[BPP_W-1:0];
        REG_RLE_MODE:        rle_mode        <= cfg.data[0];
        REG_FIRST_ROW_TOP:   first_row_top   <= cfg.data[0];
        REG_RIGHT_TO_LEFT:   right_to_left   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // effective image size: zero reads as one, oversize saturates to the limit
  always_comb begin
    if (image_width == '0) begin
      width_lim = COL_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_lim = COL_W'(MAX_WIDTH);
    end else begin
      width_lim = COL_W'(image_width);
    end
    if (image_height == '0) begin
      height_lim = ROW_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height_lim = ROW_W'(MAX_HEIGHT);
    end else begin
      height_lim = ROW_W'(image_height);
    end
  end

  // ---------------- byte decode ----------------
  assign pixel_in.ready = !skid_valid;
  assign accept         = pixel_in.valid && pixel_in.ready;
  assign tag_step       = rle_mode && expect_tag;
  assign last_byte      = (bytes_per_pixel == BPP_BGRA) ? 2'd3 : 2'd2;
  assign pixel_done     = byte_in_pixel >= last_byte;
  assign packet_dec     = (packet_left != 8'd0) ? (packet_left - 8'd1) : 8'd0;

  // B, G, R land in the held color; the alpha byte is dropped
  always_comb begin
    case (byte_in_pixel)
      2'd0:    color_new = {color_hold[23:8], pixel_in.data_byte};
      2'd1:    color_new = {color_hold[23:16], pixel_in.data_byte, color_hold[7:0]};
      2'd2:    color_new = {pixel_in.data_byte, color_hold[15:0]};
      default: color_new = color_hold;
    endcase
  end

  // how many pixels this completed pixel asks for
  always_comb begin
    if (rle_mode && packet_is_run) begin
      want       = (packet_left == 8'd0) ? 8'd1 : packet_left;
      more_after = 1'b0;
    end else if (rle_mode) begin
      want       = 8'd1;
      more_after = packet_dec != 8'd0;
    end else begin
      want       = 8'd1;
      more_after = 1'b0;
    end
  end

  // a completed pixel is emitted unless the image is finished or the rest of a clipped literal is being dropped
  assign do_emit = !finished && !tag_step && pixel_done &&
                   (!rle_mode || packet_is_run || !drop_rest);

  // ---------------- span placement ----------------
  assign col_sat = (column_count >= width_lim) ? (width_lim - COL_W'(1)) : column_count;
  assign row_sat = (row_count >= height_lim) ? (height_lim - ROW_W'(1)) : row_count;
  assign room    = width_lim - col_sat;
  assign want_x  = SPAN_W'(want);
  assign room_x  = SPAN_W'(room);
  assign overrun = want_x > room_x;
  assign len_x   = overrun ? room_x : want_x;
  // cut at row end, or a literal packet that still has pixels past the row end
  assign clip    = overrun || ((len_x == room_x) && more_after);
  assign col_sum = col_sat + COL_W'(len_x);
  assign row_end = col_sum >= width_lim;
  assign row_inc = row_sat + ROW_W'(1);
  assign last_row = row_inc >= height_lim;

  // flip flags map stream order to image coordinates
  assign row_pos = first_row_top ? row_sat : (height_lim - ROW_W'(1) - row_sat);
  assign col_pos = right_to_left ? (width_lim - COL_W'(1) - col_sat) : col_sat;

  assign key = is_key(color_new[23:16], color_new[15:8], color_new[7:0]);

  always_comb begin
    result_span.row_index    = COORD_W'(row_pos);
    result_span.first_column = COORD_W'(col_pos);
    result_span.span_length  = len_x[LEN_W-1:0];
    result_span.red          = key ? COLOR_FULL : color_new[23:16];
    result_span.green        = key ? COLOR_NONE : color_new[15:8];
    result_span.blue         = key ? COLOR_FULL : color_new[7:0];
    result_span.keyed        = key;
    result_span.clipped      = clip;
    result_span.image_done   = row_end && last_row;
  end

  assign result_valid = accept && do_emit;

  // ---------------- next state ----------------
  always_comb begin
    expect_tag_next    = expect_tag;
    packet_is_run_next = packet_is_run;
    packet_left_next   = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    color_hold_next    = color_hold;
    row_count_next     = row_count;
    column_count_next  = column_count;
    finished_next      = finished;
    drop_rest_next     = drop_rest;

    if (accept && !finished) begin
      if (tag_step) begin
        // packet header: run flag and count minus one
        packet_is_run_next = pixel_in.data_byte[TAG_RUN_BIT];
        packet_left_next   = (pixel_in.data_byte & TAG_COUNT_MASK) + 8'd1;
        expect_tag_next    = 1'b0;
        byte_in_pixel_next = 2'd0;
        drop_rest_next     = 1'b0;
      end else begin
        color_hold_next    = color_new;
        byte_in_pixel_next = pixel_done ? 2'd0 : (byte_in_pixel + 2'd1);
        if (pixel_done) begin
          if (do_emit) begin
            if (row_end) begin
              column_count_next = '0;
              row_count_next    = row_inc;
              if (last_row) begin
                finished_next = 1'b1;
              end
            end else begin
              column_count_next = col_sum;
              row_count_next    = row_sat;
            end
          end
          if (rle_mode && packet_is_run) begin
            // whatever did not fit in the row is lost
            packet_left_next = 8'd0;
            expect_tag_next  = 1'b1;
          end else if (rle_mode) begin
            packet_left_next = packet_dec;
            if (!drop_rest && row_end && packet_dec != 8'd0) begin
              drop_rest_next = 1'b1;
            end
            if (packet_dec == 8'd0) begin
              expect_tag_next = 1'b1;
              drop_rest_next  = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_tag    <= 1'b1;
      packet_is_run <= 1'b0;
      packet_left   <= 8'd0;
      byte_in_pixel <= 2'd0;
      color_hold    <= 24'd0;
      row_count     <= '0;
      column_count  <= '0;
      finished      <= 1'b0;
      drop_rest     <= 1'b0;
    end else begin
      expect_tag    <= expect_tag_next;
      packet_is_run <= packet_is_run_next;
      packet_left   <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      color_hold    <= color_hold_next;
      row_count     <= row_count_next;
      column_count  <= column_count_next;
      finished      <= finished_next;
      drop_rest     <= drop_rest_next;
    end
  end

  // ---------------- output register with skid word ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || span_out.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= result_valid;
      end
    end else if (result_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || span_out.ready) begin
      out_span <= skid_valid ? skid_span : result_span;
    end
    if (out_valid && !span_out.ready && result_valid) begin
      skid_span <= result_span;
    end
  end

  assign span_out.valid        = out_valid;
  assign span_out.row_index    = out_span.row_index;
  assign span_out.first_column = out_span.first_column;
  assign span_out.span_length  = out_span.span_length;
  assign span_out.red          = out_span.red;
  assign span_out.green        = out_span.green;
  assign span_out.blue         = out_span.blue;
  assign span_out.keyed        = out_span.keyed;
  assign span_out.clipped      = out_span.clipped;
  assign span_out.image_done   = out_span.image_done;

endmodule

/* sv/tpsd_checker.sv */
// port-level checker of the pixel stream decoder, bound to the top level
// depends on tpsd_pkg, tpsd_if and tga_pixel_stream_decoder_unit_macros.svh
`timescale 1ns / 1ps
`include "tga_pixel_stream_decoder_unit_macros.svh"

module tpsd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tpsd_pkg::COORD_W-1:0] row_index,
  input logic [tpsd_pkg::COORD_W-1:0] first_column,
  input logic [tpsd_pkg::LEN_W-1:0]   span_length,
  input logic [tpsd_pkg::COLOR_W-1:0] red,
  input logic [tpsd_pkg::COLOR_W-1:0] green,
  input logic [tpsd_pkg::COLOR_W-1:0] blue,
  input logic                         keyed,
  input logic                         clipped,
  input logic                         image_done
);
  import tpsd_pkg::*;

  // a stalled word stays put
  `TPSD_ASSERT_NEXT(a_span_hold, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(first_column) && $stable(span_length) && $stable(red) && $stable(green) && $stable(blue) && $stable(keyed) && $stable(clipped) && $stable(image_done))

  // span never empty and never longer than one packet
  `TPSD_ASSERT_NOW(a_len_range, out_valid, span_length != 8'd0 && span_length <= 8'd128)

  // keyed colors come out magenta
  `TPSD_ASSERT_NOW(a_key_color, out_valid && keyed, red == COLOR_FULL && green == COLOR_NONE && blue == COLOR_FULL)

  // nothing follows the span that closes the image
  `TPSD_ASSERT_NEXT(a_done_last, out_valid && out_ready && image_done, !out_valid)

  // input backs off only while the output stage holds words
  `TPSD_ASSERT_NOW(a_ready_full, !in_ready, out_valid)

endmodule

bind tga_pixel_stream_decoder_unit tpsd_checker u_tpsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pixel_in.ready),
  .out_valid    (span_out.valid),
  .out_ready    (span_out.ready),
  .row_index    (span_out.row_index),
  .first_column (span_out.first_column),
  .span_length  (span_out.span_length),
  .red          (span_out.red),
  .green        (span_out.green),
  .blue         (span_out.blue),
  .keyed        (span_out.keyed),
  .clipped      (span_out.clipped),
  .image_done   (span_out.image_done)
);
